### rtl/core/dtmfr_pkg.sv
`default_nettype none

package dtmfr_pkg;

    localparam int NUM_TONES = 4;
    localparam int ACC_WIDTH = 48;
    localparam int SAMPLE_W  = 16;
    localparam int COEFF_W   = 18;
    localparam int FRAC_W    = 16;
    localparam int DIGIT_W   = 16;

    localparam int TONE_W = (NUM_TONES > 1) ? $clog2(NUM_TONES) : 1;

    // coeff * q1 product and its digit split
    localparam int PROD_W   = COEFF_W + ACC_WIDTH;
    localparam int Q_DIGITS = (ACC_WIDTH + DIGIT_W - 1) / DIGIT_W;
    localparam int P_DIGITS = (PROD_W + DIGIT_W - 1) / DIGIT_W;
    localparam int Q_EXT_W  = Q_DIGITS * DIGIT_W;
    localparam int P_EXT_W  = P_DIGITS * DIGIT_W;
    localparam int DIG_W    = $clog2(P_DIGITS);
    localparam int SH_W     = $clog2(P_DIGITS);

    // power accumulator: 2^16*(q1^2 + q2^2) - coeff*q1*q2 fits with margin
    localparam int PWR_W = 2 * ACC_WIDTH + COEFF_W + 2;

    // resonator update datapath
    localparam int RND_W = PROD_W - FRAC_W + 1;
    localparam int UPD_W = RND_W + 2;

    // power sequence steps for one tone
    localparam int PS_COEF   = 0;
    localparam int PS_Q1     = PS_COEF + 1;
    localparam int PS_Q2     = PS_Q1 + Q_DIGITS;
    localparam int PS_P      = PS_Q2 + Q_DIGITS;
    localparam int PS_SETTLE = PS_P + P_DIGITS;
    localparam int PS_CMP    = PS_SETTLE + 1;
    localparam int STEP_W    = $clog2(PS_CMP + 1);

    localparam logic signed [COEFF_W-1:0] COEFF_RESET [NUM_TONES] = '{
        18'sd130522, 18'sd130441, 18'sd130262, 18'sd130060
    };

    typedef struct packed {
        logic            en;
        logic            first;
        logic            sub;
        logic            cap;
        logic [SH_W-1:0] sh;
    } mac_ctl_t;

endpackage

`default_nettype wire

### rtl/core/dtmfr_sample_if.sv
`default_nettype none

interface dtmfr_sample_if;
    import dtmfr_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_sample;

    modport source (output valid, output sample, output last_sample, input ready);
    modport sink   (input valid, input sample, input last_sample, output ready);

endinterface

`default_nettype wire

### rtl/core/dtmfr_mask_if.sv
`default_nettype none

interface dtmfr_mask_if;
    import dtmfr_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [NUM_TONES-1:0] tone_mask;

    modport source (output valid, output tone_mask, input ready);
    modport sink   (input valid, input tone_mask, output ready);

endinterface

`default_nettype wire

### rtl/core/dtmf_row_goertzel_detector.sv
`default_nettype none

// DTMF row-tone detector. Each transfer on audio carries one signed 16-bit
// sample and runs it through four Goertzel resonators (coefficients 2cos(w) in
// Q2.16, to be written by the user through the cfg port while idle; the block
// does not enforce this). All multiplications use one shared 18x48 signed
// multiplier with a registered product. Tones are updated in turn and audio is
// ready only in idle, so the next sample waits for every tone. A sample marked
// last_sample is followed by the power pass (multiplier steps and a compare per
// tone), then the result register is loaded once it is free; tones then carries
// a 4-bit mask of the tones whose power equals the maximum, and the resonators
// are cleared. A result waiting on tones does not stop new samples being taken.
module dtmf_row_goertzel_detector (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    dtmfr_sample_if.sink                          audio,
    dtmfr_mask_if.source                          tones,
    input  wire logic                             cfg_wr_en,
    input  wire logic [dtmfr_pkg::TONE_W-1:0]     cfg_index,
    input  wire logic [dtmfr_pkg::COEFF_W-1:0]    cfg_data
);
    import dtmfr_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_UPD  = 4'b0010,
        ST_PWR  = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    localparam logic signed [ACC_WIDTH-1:0] Q_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_WIDTH-1:0] Q_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};
    localparam logic signed [PROD_W:0]      ROUND_HALF = (PROD_W+1)'(1) << (FRAC_W - 1);

    state_t                      state_reg, state_next;
    logic [TONE_W-1:0]           tone_reg, tone_next;
    logic [STEP_W-1:0]           step_reg, step_next;
    mac_ctl_t                    ctl_reg, ctl_next;
    logic                        out_valid_reg, out_valid_next;
    logic signed [COEFF_W-1:0]   coeff_reg [NUM_TONES];
    logic signed [ACC_WIDTH-1:0] q1_reg [NUM_TONES];
    logic signed [ACC_WIDTH-1:0] q2_reg [NUM_TONES];
    logic signed [ACC_WIDTH-1:0] q1_next [NUM_TONES];
    logic signed [ACC_WIDTH-1:0] q2_next [NUM_TONES];

    logic signed [SAMPLE_W-1:0]  x_reg, x_next;
    logic                        last_reg, last_next;
    logic signed [PROD_W-1:0]    prod_reg, prod_next;
    logic signed [PROD_W-1:0]    p_reg, p_next;
    logic signed [PWR_W-1:0]     acc_reg, acc_next;
    logic signed [PWR_W-1:0]     best_reg, best_next;
    logic [NUM_TONES-1:0]        mask_reg, mask_next;
    logic [NUM_TONES-1:0]        out_mask_reg, out_mask_next;

    logic signed [COEFF_W-1:0]   coeff_cur;
    logic signed [ACC_WIDTH-1:0] q1_cur;
    logic signed [ACC_WIDTH-1:0] q2_cur;
    logic signed [COEFF_W-1:0]   mul_a;
    logic signed [ACC_WIDTH-1:0] mul_b;
    logic signed [Q_EXT_W-1:0]   q1_ext;
    logic signed [Q_EXT_W-1:0]   q2_ext;
    logic signed [P_EXT_W-1:0]   p_ext;
    logic [STEP_W-1:0]           k_raw;
    logic [DIG_W-1:0]            dig_k;
    logic [DIGIT_W-1:0]          dig;
    logic                        dig_top;

    logic signed [PWR_W-1:0]     prod_wide;
    logic signed [PWR_W-1:0]     acc_term;
    logic signed [PWR_W-1:0]     acc_base;

    logic signed [PROD_W:0]      rnd_sum;
    logic signed [RND_W-1:0]     rnd;
    logic signed [UPD_W-1:0]     upd_sum;
    logic [UPD_W-ACC_WIDTH:0]    upd_hi;
    logic signed [ACC_WIDTH-1:0] upd_val;
    logic [NUM_TONES-1:0]        tone_bit;
    logic                        last_tone;

    assign coeff_cur = coeff_reg[tone_reg];
    assign q1_cur    = q1_reg[tone_reg];
    assign q2_cur    = q2_reg[tone_reg];
    assign q1_ext    = Q_EXT_W'(q1_cur);
    assign q2_ext    = Q_EXT_W'(q2_cur);
    assign p_ext     = P_EXT_W'(p_reg);
    assign tone_bit  = NUM_TONES'(1) << tone_reg;
    assign last_tone = (tone_reg == TONE_W'(NUM_TONES - 1));

    assign audio.ready     = (state_reg == ST_IDLE);
    assign tones.valid     = out_valid_reg;
    assign tones.tone_mask = out_mask_reg;

    // Operand select for the shared multiplier and the accumulate control, which
    // is registered alongside the product.
    always_comb
    begin
        mul_a    = coeff_cur;
        mul_b    = q1_cur;
        ctl_next = '0;
        k_raw    = '0;
        dig_k    = '0;
        dig      = '0;
        dig_top  = 1'b0;
        if (state_reg == ST_PWR)
        begin
            priority if (step_reg == STEP_W'(PS_COEF))
            begin
                ctl_next.cap = 1'b1;
            end
            else if (step_reg < STEP_W'(PS_Q2))
            begin
                k_raw         = step_reg - STEP_W'(PS_Q1);
                dig_k         = k_raw[DIG_W-1:0];
                dig           = q1_ext[DIGIT_W*dig_k +: DIGIT_W];
                dig_top       = (k_raw == STEP_W'(Q_DIGITS - 1));
                mul_a         = dig_top ? COEFF_W'($signed(dig)) : COEFF_W'(dig);
                mul_b         = q1_cur;
                ctl_next.en   = 1'b1;
                ctl_next.first = (k_raw == '0);
                ctl_next.sh   = SH_W'(dig_k) + SH_W'(1);
            end
            else if (step_reg < STEP_W'(PS_P))
            begin
                k_raw       = step_reg - STEP_W'(PS_Q2);
                dig_k       = k_raw[DIG_W-1:0];
                dig         = q2_ext[DIGIT_W*dig_k +: DIGIT_W];
                dig_top     = (k_raw == STEP_W'(Q_DIGITS - 1));
                mul_a       = dig_top ? COEFF_W'($signed(dig)) : COEFF_W'(dig);
                mul_b       = q2_cur;
                ctl_next.en = 1'b1;
                ctl_next.sh = SH_W'(dig_k) + SH_W'(1);
            end
            else if (step_reg < STEP_W'(PS_SETTLE))
            begin
                k_raw        = step_reg - STEP_W'(PS_P);
                dig_k        = k_raw[DIG_W-1:0];
                dig          = p_ext[DIGIT_W*dig_k +: DIGIT_W];
                dig_top      = (k_raw == STEP_W'(P_DIGITS - 1));
                mul_a        = dig_top ? COEFF_W'($signed(dig)) : COEFF_W'(dig);
                mul_b        = q2_cur;
                ctl_next.en  = 1'b1;
                ctl_next.sub = 1'b1;
                ctl_next.sh  = SH_W'(dig_k);
            end
            else
            begin
                ctl_next = '0;
            end
        end
    end

    assign prod_next = mul_a * mul_b;

    // Accumulate the product registered in the previous cycle, or capture it as p.
    always_comb
    begin
        prod_wide = PWR_W'(prod_reg);
        acc_term  = prod_wide << (DIGIT_W * ctl_reg.sh);
        acc_base  = ctl_reg.first ? '0 : acc_reg;
        acc_next  = acc_reg;
        p_next    = p_reg;
        if (ctl_reg.en)
        begin
            acc_next = ctl_reg.sub ? (acc_base - acc_term) : (acc_base + acc_term);
        end
        if (ctl_reg.cap)
        begin
            p_next = prod_reg;
        end
    end

    // Resonator update: round half up, subtract q2, add the sample, clamp.
    always_comb
    begin
        rnd_sum = (PROD_W+1)'(prod_reg) + ROUND_HALF;
        rnd     = rnd_sum[PROD_W:FRAC_W];
        upd_sum = UPD_W'(rnd) - UPD_W'(q2_cur) + UPD_W'(x_reg);
        upd_hi  = upd_sum[UPD_W-1:ACC_WIDTH-1];
        if ((&upd_hi) || !(|upd_hi))
        begin
            upd_val = upd_sum[ACC_WIDTH-1:0];
        end
        else
        begin
            upd_val = upd_sum[UPD_W-1] ? Q_MIN : Q_MAX;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        tone_next      = tone_reg;
        step_next      = step_reg;
        q1_next        = q1_reg;
        q2_next        = q2_reg;
        x_next         = x_reg;
        last_next      = last_reg;
        best_next      = best_reg;
        mask_next      = mask_reg;
        out_mask_next  = out_mask_reg;
        out_valid_next = out_valid_reg && !tones.ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (audio.valid)
                begin
                    x_next     = audio.sample;
                    last_next  = audio.last_sample;
                    tone_next  = '0;
                    step_next  = '0;
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                if (step_reg == '0)
                begin
                    step_next = STEP_W'(1);
                end
                else
                begin
                    q2_next[tone_reg] = q1_cur;
                    q1_next[tone_reg] = upd_val;
                    step_next         = '0;
                    if (last_tone)
                    begin
                        tone_next  = '0;
                        state_next = last_reg ? ST_PWR : ST_IDLE;
                    end
                    else
                    begin
                        tone_next = tone_reg + TONE_W'(1);
                    end
                end
            end
            ST_PWR:
            begin
                if (step_reg == STEP_W'(PS_CMP))
                begin
                    // keep every tone that ties the running maximum
                    if ((tone_reg == '0) || (acc_reg > best_reg))
                    begin
                        best_next = acc_reg;
                        mask_next = tone_bit;
                    end
                    else if (acc_reg == best_reg)
                    begin
                        mask_next = mask_reg | tone_bit;
                    end
                    step_next = '0;
                    if (last_tone)
                    begin
                        tone_next  = '0;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        tone_next = tone_reg + TONE_W'(1);
                    end
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || tones.ready)
                begin
                    out_mask_next  = mask_reg;
                    out_valid_next = 1'b1;
                    for (int i = 0; i < NUM_TONES; i++)
                    begin
                        q1_next[i] = '0;
                        q2_next[i] = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tone_reg      <= '0;
            step_reg      <= '0;
            ctl_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_TONES; i++)
            begin
                coeff_reg[i] <= COEFF_RESET[i];
                q1_reg[i]    <= '0;
                q2_reg[i]    <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            tone_reg      <= tone_next;
            step_reg      <= step_next;
            ctl_reg       <= ctl_next;
            out_valid_reg <= out_valid_next;
            q1_reg        <= q1_next;
            q2_reg        <= q2_next;
            if (cfg_wr_en && (int'(cfg_index) < NUM_TONES))
            begin
                coeff_reg[cfg_index] <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        last_reg     <= last_next;
        prod_reg     <= prod_next;
        p_reg        <= p_next;
        acc_reg      <= acc_next;
        best_reg     <= best_next;
        mask_reg     <= mask_next;
        out_mask_reg <= out_mask_next;
    end

endmodule

`default_nettype wire

### test/dtmf_row_goertzel_detector_test.sv
`default_nettype none

module dtmf_row_goertzel_detector_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dtmfr_pkg::*;

    localparam int REG_COEFF_ROW0 = 0;
    localparam int REG_COEFF_ROW1 = 1;
    localparam int REG_COEFF_ROW2 = 2;
    localparam int REG_COEFF_ROW3 = 3;

    localparam logic [COEFF_W-1:0] COEFF_697 = 18'd130522;
    localparam logic [COEFF_W-1:0] COEFF_770 = 18'd130441;
    localparam logic [COEFF_W-1:0] COEFF_852 = 18'd130262;
    localparam logic [COEFF_W-1:0] COEFF_941 = 18'd130060;
    localparam logic [COEFF_W-1:0] COEFF_MAX = 18'h1ffff;
    localparam logic [COEFF_W-1:0] COEFF_MIN = 18'h20000;
    localparam logic [COEFF_W-1:0] COEFF_ONE = 18'h10000;

    localparam int  STALL_LIMIT  = 5000;
    localparam int  DRAIN_CYCLES = 100;
    localparam int  HOLD_CYCLES  = 600;
    localparam int  NYQUIST_LEN  = 64;
    localparam real TWO_PI       = 6.283185307179586;

    typedef logic signed [191:0] wide_t;

    localparam wide_t ACC_MAX = {{(193 - ACC_WIDTH){1'b0}}, {(ACC_WIDTH - 1){1'b1}}};
    localparam wide_t ACC_MIN = ~ACC_MAX;

    typedef struct packed {
        logic [SAMPLE_W-1:0]  sample;
        logic                 last;
        logic                 fixed;
        logic [NUM_TONES-1:0] fixed_mask;
    } audio_item_t;

    // single-sample and all-zero blocks give every tone the same power
    localparam audio_item_t DIRECTED [21] = '{
        '{16'h7fff, 1'b1, 1'b1, 4'hf},
        '{16'h8000, 1'b1, 1'b1, 4'hf},
        '{16'h0000, 1'b1, 1'b1, 4'hf},
        '{16'h0001, 1'b1, 1'b1, 4'hf},
        '{16'hffff, 1'b1, 1'b1, 4'hf},
        '{16'h7fff, 1'b0, 1'b0, 4'h0},
        '{16'h7fff, 1'b1, 1'b0, 4'h0},
        '{16'h8000, 1'b0, 1'b0, 4'h0},
        '{16'h8000, 1'b0, 1'b0, 4'h0},
        '{16'h8000, 1'b1, 1'b0, 4'h0},
        '{16'h5555, 1'b0, 1'b0, 4'h0},
        '{16'haaaa, 1'b0, 1'b0, 4'h0},
        '{16'h7fff, 1'b0, 1'b0, 4'h0},
        '{16'h8000, 1'b1, 1'b0, 4'h0},
        '{16'h0000, 1'b0, 1'b0, 4'h0},
        '{16'h0000, 1'b0, 1'b0, 4'h0},
        '{16'h0000, 1'b0, 1'b0, 4'h0},
        '{16'h0000, 1'b1, 1'b1, 4'hf},
        '{16'h0000, 1'b0, 1'b0, 4'h0},
        '{16'h0001, 1'b0, 1'b0, 4'h0},
        '{16'hfffe, 1'b1, 1'b0, 4'h0}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [TONE_W-1:0]    cfg_index;
    logic [COEFF_W-1:0]   cfg_data;
    logic                 row_fixed;
    logic [NUM_TONES-1:0] row_mask;
    bit                   sender_gaps;
    bit                   hold_req;
    int                   mismatches;

    audio_item_t          sample_queue [$];
    logic [NUM_TONES-1:0] expected_masks [$];

    logic signed [COEFF_W-1:0]   coeff_m [NUM_TONES];
    logic signed [ACC_WIDTH-1:0] res_q1  [NUM_TONES];
    logic signed [ACC_WIDTH-1:0] res_q2  [NUM_TONES];

    dtmfr_sample_if audio_ch ();
    dtmfr_mask_if   tones_ch ();

    dtmf_row_goertzel_detector u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .audio     (audio_ch),
        .tones     (tones_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Fold one sample into every resonator; on the closing sample return the
    // mask of the strongest tones and clear the resonators.
    function automatic bit goertzel_update(input logic signed [SAMPLE_W-1:0] x,
                                           input logic fin,
                                           output logic [NUM_TONES-1:0] mask);
        wide_t c;
        wide_t q1;
        wide_t q2;
        wide_t t;
        wide_t best;
        wide_t pwr [NUM_TONES];
        mask = '0;
        for (int i = 0; i < NUM_TONES; i++)
        begin
            c  = coeff_m[i];
            q1 = res_q1[i];
            q2 = res_q2[i];
            t  = ((c * q1 + 32768) >>> 16) - q2 + x;
            if (t < ACC_MIN)
                t = ACC_MIN;
            else if (t > ACC_MAX)
                t = ACC_MAX;
            res_q2[i] = res_q1[i];
            res_q1[i] = t[ACC_WIDTH-1:0];
        end
        if (!fin)
            return 1'b0;
        for (int i = 0; i < NUM_TONES; i++)
        begin
            c      = coeff_m[i];
            q1     = res_q1[i];
            q2     = res_q2[i];
            pwr[i] = ((q1 * q1 + q2 * q2) <<< 16) - c * q1 * q2;
        end
        best = pwr[0];
        for (int i = 1; i < NUM_TONES; i++)
            if (pwr[i] > best)
                best = pwr[i];
        for (int i = 0; i < NUM_TONES; i++)
        begin
            mask[i]   = (pwr[i] == best);
            res_q1[i] = '0;
            res_q2[i] = '0;
        end
        return 1'b1;
    endfunction

    function automatic void enqueue_sample(input audio_item_t item);
        sample_queue.insert(sample_queue.size(), item);
    endfunction

    function automatic void enqueue_mask(input logic [NUM_TONES-1:0] m);
        expected_masks.insert(expected_masks.size(), m);
    endfunction

    always @(posedge clk)
    begin : scoreboard
        logic [NUM_TONES-1:0] pred;
        logic [NUM_TONES-1:0] want;
        if (rst_n && audio_ch.valid && audio_ch.ready)
        begin
            if (goertzel_update(audio_ch.sample, audio_ch.last_sample, pred))
                enqueue_mask(row_fixed ? row_mask : pred);
        end
        if (rst_n && tones_ch.valid && tones_ch.ready)
        begin
            if (expected_masks.size() == 0)
            begin
                $error("tone_mask: no result expected, got %h", tones_ch.tone_mask);
                mismatches++;
            end
            else
            begin
                want = expected_masks.pop_front();
                if (want !== tones_ch.tone_mask)
                begin
                    $error("tone_mask: expected %h, got %h", want, tones_ch.tone_mask);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((audio_ch.valid && audio_ch.ready) || (tones_ch.valid && tones_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : receiver
        int             span;
        int             mode;
        bit             held;
        logic [7:0]     stall_pat;
        stall_pat      = 8'b1101_1011;
        held           = 1'b0;
        tones_ch.ready = 1'b0;
        forever
        begin
            if (hold_req && !held)
            begin
                held = 1'b1;
                @(negedge clk);
                tones_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            mode = $urandom_range(2);
            span = $urandom_range(5, 40);
            repeat (span)
            begin
                @(negedge clk);
                case (mode)
                    0: tones_ch.ready <= 1'b1;
                    1: tones_ch.ready <= ($urandom_range(2) != 0);
                    default:
                    begin
                        tones_ch.ready <= stall_pat[0];
                        stall_pat = {stall_pat[0], stall_pat[7:1]};
                    end
                endcase
            end
        end
    end

    task automatic write_coeff(input int idx, input logic [COEFF_W-1:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx[TONE_W-1:0];
        cfg_data  <= value;
        coeff_m[idx] = value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_coeffs(input logic [COEFF_W-1:0] c0, input logic [COEFF_W-1:0] c1,
                              input logic [COEFF_W-1:0] c2, input logic [COEFF_W-1:0] c3);
        write_coeff(REG_COEFF_ROW0, c0);
        write_coeff(REG_COEFF_ROW1, c1);
        write_coeff(REG_COEFF_ROW2, c2);
        write_coeff(REG_COEFF_ROW3, c3);
    endtask

    // Offer queued samples in bursts; hold valid high across back-to-back transfers.
    task automatic drive_items();
        audio_item_t it;
        int          burst;
        burst = 0;
        while (sample_queue.size() > 0)
        begin
            it = sample_queue.pop_front();
            @(negedge clk);
            if (burst == 0)
            begin
                if (sender_gaps && $urandom_range(3) != 0)
                begin
                    audio_ch.valid <= 1'b0;
                    repeat ($urandom_range(1, 12)) @(negedge clk);
                end
                burst = $urandom_range(1, 30);
            end
            burst--;
            audio_ch.valid       <= 1'b1;
            audio_ch.sample      <= it.sample;
            audio_ch.last_sample <= it.last;
            row_fixed            <= it.fixed;
            row_mask             <= it.fixed_mask;
            do
                @(posedge clk);
            while (!audio_ch.ready);
        end
        @(negedge clk);
        audio_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        while (expected_masks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Mostly tone blocks (one row tone, or a row and a column tone) with noise;
    // the rest full-range noise and rail-to-rail blocks.
    task automatic gen_blocks(input int n_items, input int max_len);
        audio_item_t it;
        int          made;
        int          len;
        int          kind;
        int          f_row;
        int          f_col;
        int          amp;
        int          noise;
        real         tone;
        made = 0;
        while (made < n_items)
        begin
            len = ($urandom_range(4) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 24);
            if (len > max_len)
                len = $urandom_range(1, max_len);
            kind = $urandom_range(9);
            case ($urandom_range(3))
                0: f_row = 697;
                1: f_row = 770;
                2: f_row = 852;
                default: f_row = 941;
            endcase
            case ($urandom_range(3))
                0: f_col = 1209;
                1: f_col = 1336;
                2: f_col = 1477;
                default: f_col = 1633;
            endcase
            amp = $urandom_range(1000, 30000);
            for (int n = 0; n < len; n++)
            begin
                noise = $urandom_range(0, amp / 8);
                noise = noise - amp / 16;
                if (kind <= 2)
                    tone = amp * $sin(TWO_PI * f_row * n / 48000.0);
                else
                    tone = amp * 0.5 * ($sin(TWO_PI * f_row * n / 48000.0)
                                        + $sin(TWO_PI * f_col * n / 48000.0));
                if (kind <= 5)
                    it.sample = 16'($rtoi(tone) + noise);
                else if (kind <= 7)
                    it.sample = 16'($urandom);
                else
                    case ($urandom_range(3))
                        0: it.sample = 16'h7fff;
                        1: it.sample = 16'h8000;
                        2: it.sample = 16'h0000;
                        default: it.sample = 16'hffff;
                    endcase
                it.last       = (n == len - 1);
                it.fixed      = 1'b0;
                it.fixed_mask = '0;
                enqueue_sample(it);
            end
            made += len;
        end
    endtask

    task automatic run_blocks(input int n_items, input int max_len);
        gen_blocks(n_items, max_len);
        drive_items();
        drain();
    endtask

    initial
    begin : main
        audio_item_t        it;
        logic [COEFF_W-1:0] r0;
        rst_n                = 1'b0;
        cfg_wr_en            = 1'b0;
        cfg_index            = '0;
        cfg_data             = '0;
        audio_ch.valid       = 1'b0;
        audio_ch.sample      = '0;
        audio_ch.last_sample = 1'b0;
        row_fixed            = 1'b0;
        row_mask             = '0;
        sender_gaps          = 1'b1;
        hold_req             = 1'b0;
        mismatches           = 0;
        coeff_m[0]           = COEFF_697;
        coeff_m[1]           = COEFF_770;
        coeff_m[2]           = COEFF_852;
        coeff_m[3]           = COEFF_941;
        for (int i = 0; i < NUM_TONES; i++)
        begin
            res_q1[i] = '0;
            res_q2[i] = '0;
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED[i])
            enqueue_sample(DIRECTED[i]);
        drive_items();
        drain();

        run_blocks(300, 64);

        set_coeffs(COEFF_MAX, COEFF_MAX, COEFF_MAX, COEFF_MAX);
        run_blocks(80, 24);
        set_coeffs(COEFF_MIN, COEFF_MIN, COEFF_MIN, COEFF_MIN);
        run_blocks(80, 24);
        set_coeffs(COEFF_MIN, COEFF_MAX, '0, COEFF_ONE);
        run_blocks(100, 64);

        // random settings; the first repeats row 0 on row 2 to force ties
        for (int k = 0; k < 3; k++)
        begin
            r0 = 18'($urandom);
            set_coeffs(r0, 18'($urandom), (k == 0) ? r0 : 18'($urandom), 18'($urandom));
            run_blocks(120, 64);
        end

        // short blocks while the result side holds off: fill the block up
        set_coeffs(COEFF_697, COEFF_770, COEFF_852, COEFF_941);
        hold_req = 1'b1;
        run_blocks(150, 4);

        // drive rows 0 and 2 at Nyquist in one long full-swing block
        set_coeffs(COEFF_MIN, COEFF_MAX, COEFF_MIN, '0);
        sender_gaps = 1'b0;
        for (int i = 0; i < NYQUIST_LEN; i++)
        begin
            it.sample     = i[0] ? 16'h8000 : 16'h7fff;
            it.last       = (i == NYQUIST_LEN - 1);
            it.fixed      = 1'b0;
            it.fixed_mask = '0;
            enqueue_sample(it);
        end
        drive_items();
        drain();

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
rtl/core/dtmfr_pkg.sv
rtl/core/dtmfr_sample_if.sv
rtl/core/dtmfr_mask_if.sv
rtl/core/dtmf_row_goertzel_detector.sv
test/dtmf_row_goertzel_detector_test.sv
